FILE: design/dielectric_fresnel_reflectance_defines.svh
// Assertion macros for the dielectric Fresnel reflectance block.
// Used only by the port checker; no other dependencies.
`ifndef DIELECTRIC_FRESNEL_REFLECTANCE_DEFINES_SVH
`define DIELECTRIC_FRESNEL_REFLECTANCE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dfr_pkg.sv
// Package for the dielectric Fresnel reflectance pipeline.
// Fixed-point constants, step counts and the per-item pipeline record.
package dfr_pkg;

    localparam int SQRT_STEPS  = 31;
    localparam int ST_STEPS    = 30;
    localparam int RATIO_STEPS = 17;

    localparam logic [60:0] ONE_Q60 = 61'h1 << 60;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [33:0] MAG_MAX = 34'h1 << 28;

    // Record carried down the pipe; each stage fills in its own fields.
    typedef struct packed {
        logic [15:0] ei;
        logic [15:0] et;
        logic [30:0] c;
        logic [46:0] prod;
        logic        tir;
        logic [15:0] qrem;
        logic [29:0] st;
        logic [30:0] ct;
        logic [47:0] prl_den;
        logic [47:0] per_den;
        logic [47:0] prl_rem;
        logic [47:0] per_rem;
        logic [16:0] rp;
        logic [16:0] rs;
    } dfr_item_t;

endpackage

FILE: design/dfr_ifs.sv
// Valid/ready channel interfaces for the Fresnel reflectance block.
// Request carries direction, normal and indices; response carries the result.
interface dfr_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    logic signed [15:0] surf_norm_x;
    logic signed [15:0] surf_norm_y;
    logic signed [15:0] surf_norm_z;
    logic        [15:0] eta_incident;
    logic        [15:0] eta_transmitted;

    modport source (output valid, out_dir_x, out_dir_y, out_dir_z, surf_norm_x, surf_norm_y,
                    surf_norm_z, eta_incident, eta_transmitted, input ready);
    modport sink (input valid, out_dir_x, out_dir_y, out_dir_z, surf_norm_x, surf_norm_y,
                  surf_norm_z, eta_incident, eta_transmitted, output ready);
endinterface

interface dfr_rsp_if;
    logic        valid;
    logic        ready;
    logic [16:0] reflectance;
    logic        total_reflection;

    modport source (output valid, reflectance, total_reflection, input ready);
    modport sink (input valid, reflectance, total_reflection, output ready);
endinterface

FILE: design/dfr_sqrt.sv
// Pipelined integer square root, one result bit per stage, 31 stages.
// Depends on dfr_pkg; carries a dfr_item_t record alongside the operand.
module dfr_sqrt
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [60:0] x,
    input  dfr_item_t   side_in,
    output logic        out_vld,
    output logic [30:0] root,
    output dfr_item_t   side_out
);

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [61:0]           x_reg    [SQRT_STEPS];
    logic [61:0]           res_reg  [SQRT_STEPS];
    dfr_item_t             side_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [61:0] x_prev;
        logic [61:0] res_prev;
        logic        vld_prev;
        dfr_item_t   side_prev;
        logic [61:0] bit_w;
        logic [61:0] trial;
        logic [61:0] x_next;
        logic [61:0] res_next;

        if (k == 0) begin : g_first
            assign x_prev    = {1'b0, x};
            assign res_prev  = '0;
            assign vld_prev  = in_vld;
            assign side_prev = side_in;
        end else begin : g_rest
            assign x_prev    = x_reg[k-1];
            assign res_prev  = res_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign bit_w = 62'h1 << (2 * (SQRT_STEPS - 1 - k));
        assign trial = res_prev + bit_w;

        always_comb
        begin
            if (x_prev >= trial)
            begin
                x_next   = x_prev - trial;
                res_next = (res_prev >> 1) + bit_w;
            end
            else
            begin
                x_next   = x_prev;
                res_next = res_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign root     = res_reg[SQRT_STEPS-1][30:0];
    assign side_out = side_reg[SQRT_STEPS-1];

endmodule

FILE: design/dielectric_fresnel_reflectance.sv
// Dielectric Fresnel reflectance, fully pipelined: one transaction accepted per cycle.
// Two 31-stage square roots, a 30-stage sine divider and a 17-stage ratio divider set
// the pipeline depth.
// The whole pipe advances when the output register is empty or being taken.
// Reset (rst_n, async, active low) clears all valid bits; data registers are not reset.
// Depends on dfr_pkg, dfr_ifs and dfr_sqrt.
module dielectric_fresnel_reflectance
    import dfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dfr_req_if.sink  req,
    dfr_rsp_if.source rsp
);

    logic en;

    // stage 1: component products
    logic               s1_vld_reg;
    logic signed [31:0] s1_p0_reg, s1_p1_reg, s1_p2_reg;
    logic        [15:0] s1_ea_reg, s1_eb_reg;

    // stage 2: dot, swap, cosine
    logic signed [33:0] dot;
    logic               exiting;
    logic        [33:0] mag;
    logic        [33:0] mag_sat;
    logic               s2_vld_reg;
    dfr_item_t          s2_reg, s2_next;

    // stage 3: 1 - c^2
    logic [61:0] csq;
    logic        s3_vld_reg;
    logic [60:0] s3_x_reg;
    dfr_item_t   s3_reg;

    // sqrt A -> sine of incidence
    logic        sa_vld;
    logic [30:0] sf;
    dfr_item_t   sa_item;

    // stage 4: ei * sf
    logic      s4_vld_reg;
    dfr_item_t s4_reg, s4_next;

    // stage 5: total reflection test, divider seed
    logic      s5_vld_reg;
    dfr_item_t s5_reg, s5_next;

    // sine divider
    logic [ST_STEPS-1:0] std_vld_reg;
    dfr_item_t           std_reg [ST_STEPS];

    // stage 6: 1 - st^2
    logic [59:0] stsq;
    logic        s6_vld_reg;
    logic [60:0] s6_x_reg;
    dfr_item_t   s6_reg;

    // sqrt B -> transmitted cosine
    logic        sb_vld;
    logic [30:0] ct;
    dfr_item_t   sb_item;

    // stage 7: cross products
    logic        s7_vld_reg;
    dfr_item_t   s7_reg, s7_next;
    logic [46:0] s7_pa_reg, s7_pb_reg, s7_sa_reg, s7_sb_reg;

    // stage 8: numerators and denominators
    logic      s8_vld_reg;
    dfr_item_t s8_reg, s8_next;

    // ratio dividers
    logic [RATIO_STEPS-1:0] rd_vld_reg;
    dfr_item_t              rd_reg [RATIO_STEPS];

    // stage 9: squares
    dfr_item_t   rd_last;
    logic [16:0] rp_fix, rs_fix;
    logic        s9_vld_reg;
    logic        s9_tir_reg;
    logic [33:0] s9_sqp_reg, s9_sqs_reg;

    // output register
    logic [34:0] sq_sum;
    logic [17:0] refl_raw;
    logic [16:0] refl_next;
    logic        out_vld_reg;
    logic [16:0] refl_reg;
    logic        tir_reg;

    assign en        = !out_vld_reg || rsp.ready;
    assign req.ready = en;

    // ---------------- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p0_reg <= req.out_dir_x * req.surf_norm_x;
            s1_p1_reg <= req.out_dir_y * req.surf_norm_y;
            s1_p2_reg <= req.out_dir_z * req.surf_norm_z;
            s1_ea_reg <= req.eta_incident;
            s1_eb_reg <= req.eta_transmitted;
        end
    end

    // ---------------- stage 2
    assign dot = 34'(s1_p0_reg) + 34'(s1_p1_reg) + 34'(s1_p2_reg);
    assign exiting = dot[33] || (dot == '0);
    assign mag     = exiting ? 34'(-dot) : 34'(dot);
    assign mag_sat = (mag > MAG_MAX) ? MAG_MAX : mag;

    always_comb
    begin
        s2_next    = '0;
        s2_next.ei = exiting ? s1_eb_reg : s1_ea_reg;
        s2_next.et = exiting ? s1_ea_reg : s1_eb_reg;
        s2_next.c  = {mag_sat[28:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

    // ---------------- stage 3
    assign csq = 62'(s2_reg.c) * 62'(s2_reg.c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_x_reg <= ONE_Q60 - csq[60:0];
            s3_reg   <= s2_reg;
        end
    end

    dfr_sqrt u_sqrt_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .x        (s3_x_reg),
        .side_in  (s3_reg),
        .out_vld  (sa_vld),
        .root     (sf),
        .side_out (sa_item)
    );

    // ---------------- stage 4
    always_comb
    begin
        s4_next      = sa_item;
        s4_next.prod = 47'(s4_next.ei) * 47'(sf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= sa_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s4_reg <= s4_next;
    end

    // ---------------- stage 5: sine >= 1 when ei*sf >= et * 2^30; et == 0 also flags total reflection
    always_comb
    begin
        s5_next      = s4_reg;
        s5_next.tir  = (s4_reg.et == '0) || (s4_reg.prod >= {1'b0, s4_reg.et, 30'b0});
        s5_next.qrem = s4_reg.prod[45:30];
        s5_next.st   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (en)
            s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s5_reg <= s5_next;
    end

    // ---------------- sine divider, one quotient bit per stage
    for (genvar k = 0; k < ST_STEPS; k++) begin : g_std
        dfr_item_t   item_prev;
        dfr_item_t   item_next;
        logic        vld_prev;
        logic [16:0] sh;

        if (k == 0) begin : g_first
            assign item_prev = s5_reg;
            assign vld_prev  = s5_vld_reg;
        end else begin : g_rest
            assign item_prev = std_reg[k-1];
            assign vld_prev  = std_vld_reg[k-1];
        end

        assign sh = {item_prev.qrem, item_prev.prod[ST_STEPS-1-k]};

        always_comb
        begin
            item_next = item_prev;
            if (sh >= {1'b0, item_prev.et})
            begin
                item_next.qrem             = 16'(sh - {1'b0, item_prev.et});
                item_next.st[ST_STEPS-1-k] = 1'b1;
            end
            else
            begin
                item_next.qrem = sh[15:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                std_vld_reg[k] <= 1'b0;
            else if (en)
                std_vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                std_reg[k] <= item_next;
        end
    end

    // ---------------- stage 6
    assign stsq = 60'(std_reg[ST_STEPS-1].st) * 60'(std_reg[ST_STEPS-1].st);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (en)
            s6_vld_reg <= std_vld_reg[ST_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_x_reg <= ONE_Q60 - 61'(stsq);
            s6_reg   <= std_reg[ST_STEPS-1];
        end
    end

    dfr_sqrt u_sqrt_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .x        (s6_x_reg),
        .side_in  (s6_reg),
        .out_vld  (sb_vld),
        .root     (ct),
        .side_out (sb_item)
    );

    // ---------------- stage 7
    always_comb
    begin
        s7_next    = sb_item;
        s7_next.ct = ct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else if (en)
            s7_vld_reg <= sb_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_reg    <= s7_next;
            s7_pa_reg <= 47'(sb_item.et) * 47'(sb_item.c);
            s7_pb_reg <= 47'(sb_item.ei) * 47'(ct);
            s7_sa_reg <= 47'(sb_item.ei) * 47'(sb_item.c);
            s7_sb_reg <= 47'(sb_item.et) * 47'(ct);
        end
    end

    // ---------------- stage 8
    always_comb
    begin
        s8_next         = s7_reg;
        s8_next.prl_den = 48'(s7_pa_reg) + 48'(s7_pb_reg);
        s8_next.per_den = 48'(s7_sa_reg) + 48'(s7_sb_reg);
        s8_next.prl_rem = (s7_pa_reg >= s7_pb_reg) ? 48'(s7_pa_reg - s7_pb_reg)
                                                    : 48'(s7_pb_reg - s7_pa_reg);
        s8_next.per_rem = (s7_sa_reg >= s7_sb_reg) ? 48'(s7_sa_reg - s7_sb_reg)
                                                    : 48'(s7_sb_reg - s7_sa_reg);
        s8_next.rp      = '0;
        s8_next.rs      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_vld_reg <= 1'b0;
        else if (en)
            s8_vld_reg <= s7_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s8_reg <= s8_next;
    end

    // ---------------- ratio dividers; first stage tests the 1.0 bit unshifted
    for (genvar j = 0; j < RATIO_STEPS; j++) begin : g_rd
        dfr_item_t   item_prev;
        dfr_item_t   item_next;
        logic        vld_prev;
        logic [48:0] sh_p;
        logic [48:0] sh_s;

        if (j == 0) begin : g_first
            assign item_prev = s8_reg;
            assign vld_prev  = s8_vld_reg;
            assign sh_p      = {1'b0, s8_reg.prl_rem};
            assign sh_s      = {1'b0, s8_reg.per_rem};
        end else begin : g_rest
            assign item_prev = rd_reg[j-1];
            assign vld_prev  = rd_vld_reg[j-1];
            assign sh_p      = {rd_reg[j-1].prl_rem, 1'b0};
            assign sh_s      = {rd_reg[j-1].per_rem, 1'b0};
        end

        always_comb
        begin
            item_next = item_prev;
            if (sh_p >= {1'b0, item_prev.prl_den})
            begin
                item_next.prl_rem                = 48'(sh_p - {1'b0, item_prev.prl_den});
                item_next.rp[RATIO_STEPS-1-j] = 1'b1;
            end
            else
            begin
                item_next.prl_rem = sh_p[47:0];
            end
            if (sh_s >= {1'b0, item_prev.per_den})
            begin
                item_next.per_rem                = 48'(sh_s - {1'b0, item_prev.per_den});
                item_next.rs[RATIO_STEPS-1-j] = 1'b1;
            end
            else
            begin
                item_next.per_rem = sh_s[47:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rd_vld_reg[j] <= 1'b0;
            else if (en)
                rd_vld_reg[j] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                rd_reg[j] <= item_next;
        end
    end

    // ---------------- stage 9: zero denominator reads as 1.0
    assign rd_last = rd_reg[RATIO_STEPS-1];
    assign rp_fix  = (rd_last.prl_den == '0) ? ONE_Q16 : rd_last.rp;
    assign rs_fix  = (rd_last.per_den == '0) ? ONE_Q16 : rd_last.rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_vld_reg <= 1'b0;
        else if (en)
            s9_vld_reg <= rd_vld_reg[RATIO_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_tir_reg <= rd_last.tir;
            s9_sqp_reg <= 34'(rp_fix) * 34'(rp_fix);
            s9_sqs_reg <= 34'(rs_fix) * 34'(rs_fix);
        end
    end

    // ---------------- output register
    assign sq_sum   = 35'(s9_sqp_reg) + 35'(s9_sqs_reg);
    assign refl_raw = sq_sum[34:17];

    always_comb
    begin
        if (s9_tir_reg || (refl_raw > 18'(ONE_Q16)))
            refl_next = ONE_Q16;
        else
            refl_next = refl_raw[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= s9_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            refl_reg <= refl_next;
            tir_reg  <= s9_tir_reg;
        end
    end

    assign rsp.valid            = out_vld_reg;
    assign rsp.reflectance      = refl_reg;
    assign rsp.total_reflection = tir_reg;

endmodule

FILE: design/dfr_checker.sv
// Port-level checker for dielectric_fresnel_reflectance, attached by bind.
// Uses the assertion macros from dielectric_fresnel_reflectance_defines.svh.
`include "dielectric_fresnel_reflectance_defines.svh"

module dfr_checker
    import dfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [16:0] reflectance,
    input logic        total_reflection
);

    `DFR_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(reflectance) && $stable(total_reflection), "response changed while stalled")
    `DFR_ASSERT_IMPLY(a_accept_free, clk, rst_n, !rsp_valid || rsp_ready, req_ready, "request not taken with output free")
    `DFR_ASSERT_IMPLY(a_tir_one, clk, rst_n, rsp_valid && total_reflection, reflectance == ONE_Q16, "total reflection without reflectance 1.0")
    `DFR_ASSERT_IMPLY(a_range, clk, rst_n, rsp_valid, reflectance <= ONE_Q16, "reflectance above 1.0")

endmodule

bind dielectric_fresnel_reflectance dfr_checker u_dfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .reflectance      (rsp.reflectance),
    .total_reflection (rsp.total_reflection)
);
